[sv/cartridge_bank_mapper_assert.svh]
// assertion macros for the cartridge bank mapper
`ifndef CARTRIDGE_BANK_MAPPER_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_ASSERT_SVH

`ifndef SYNTHESIS

`define CBM_ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("cbm assertion failed");

`define CBM_ASSERT(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("cbm assertion failed");

`else

`define CBM_ASSERT_RST(label, clk, rstn, prop)

`define CBM_ASSERT(label, clk, prop)

`endif

`endif

[sv/cbm_pkg.sv]
package cbm_pkg;

    localparam int ROM_BANK_BITS_DEF = 7;
    localparam int PHYS_W            = 21;

    // result targets
    localparam logic [2:0] TGT_NONE    = 3'd0;
    localparam logic [2:0] TGT_ROM     = 3'd1;
    localparam logic [2:0] TGT_RAM     = 3'd2;
    localparam logic [2:0] TGT_MAIN    = 3'd3;
    localparam logic [2:0] TGT_SPECIAL = 3'd4;

    // controller kinds
    localparam logic [1:0] MAPPER_NONE = 2'd0;
    localparam logic [1:0] MAPPER_MBC1 = 2'd1;
    localparam logic [1:0] MAPPER_MBC2 = 2'd2;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // control write regions, address bits 14:13
    localparam logic [1:0] REG_RAM_EN  = 2'd0;
    localparam logic [1:0] REG_ROM_LO  = 2'd1;
    localparam logic [1:0] REG_ROM_HI  = 2'd2;
    localparam logic [1:0] REG_MODE    = 2'd3;

    localparam logic [3:0] RAM_EN_KEY  = 4'hA;
    localparam logic [7:0] ROM_LO_MASK = 8'd31;
    localparam logic [7:0] ROM_HI_MASK = 8'd224;

    localparam logic [15:0] ADDR_ROM_LO   = 16'h4000;
    localparam logic [15:0] ADDR_VRAM     = 16'h8000;
    localparam logic [15:0] ADDR_RAM_LO   = 16'hA000;
    localparam logic [15:0] ADDR_WRAM     = 16'hC000;
    localparam logic [15:0] ADDR_ECHO_LO  = 16'hE000;
    localparam logic [15:0] ADDR_ECHO_HI  = 16'hFE00;
    localparam logic [15:0] ADDR_RSVD_LO  = 16'hFEA0;
    localparam logic [15:0] ADDR_RSVD_HI  = 16'hFEFF;
    localparam logic [15:0] ADDR_DIV      = 16'hFF04;
    localparam logic [15:0] ADDR_TAC      = 16'hFF07;
    localparam logic [15:0] ADDR_LY       = 16'hFF44;
    localparam logic [15:0] ADDR_DMA      = 16'hFF46;

    typedef struct packed {
        logic        valid;
        logic [15:0] address;
        logic [7:0]  data;
    } ctrl_wr_t;

    typedef struct packed {
        logic [1:0] ram_bank;
        logic       ram_enabled;
    } ram_stat_t;

endpackage

[sv/cartridge_bank_mapper.sv]
// channel   dir  tdata                                tuser
// s_        in   [15:0] address, [23:16] write_data   [0] operation
// m_        out  [20:0] physical_address, pad zero    [2:0] target, [3] mirror_write
// cfg_      in   cfg_data[1:0] mapper_kind            -
//
// one access per cycle sustained while m_tready is high; m_tvalid rises after the s_ transfer passes the
// input register, then decode and bank update, then the result register
// bank state moves when an access leaves the input register, so the next access sees it
// m_tready low stalls the result register; one more access still fills the input register
// aresetn is synchronous: bank 1, ram bank 0, ram disabled, rom banking mode, no controller
module cartridge_bank_mapper #(
    parameter int ROM_BANK_BITS = cbm_pkg::ROM_BANK_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address, write_data
    input  logic [0:0]  s_tuser,   // operation

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // physical_address, zero pad
    output logic [3:0]  m_tuser,   // target, mirror_write

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);

    logic                        in_valid_reg;
    logic                        in_op_reg;
    logic [15:0]                 in_addr_reg;
    logic [7:0]                  in_data_reg;

    logic                        out_valid_reg;
    logic [2:0]                  out_target_reg;
    logic [cbm_pkg::PHYS_W-1:0]  out_phys_reg;
    logic                        out_mirror_reg;

    logic [1:0]                  mapper_kind_reg;

    logic                        advance;
    cbm_pkg::ctrl_wr_t           ctrl_wr;
    cbm_pkg::ram_stat_t          ram_stat;
    logic [ROM_BANK_BITS-1:0]    rom_bank;
    logic [2:0]                  dec_target;
    logic [cbm_pkg::PHYS_W-1:0]  dec_phys;
    logic                        dec_mirror;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            mapper_kind_reg <= cbm_pkg::MAPPER_NONE;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_valid && cfg_ready) begin
                mapper_kind_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser[0];
            in_addr_reg <= s_tdata[15:0];
            in_data_reg <= s_tdata[23:16];
        end
        if (advance && in_valid_reg) begin
            out_target_reg <= dec_target;
            out_phys_reg   <= dec_phys;
            out_mirror_reg <= dec_mirror;
        end
    end

    // bank registers change only when the control write moves on
    assign ctrl_wr.valid   = advance && in_valid_reg && (in_op_reg == cbm_pkg::OP_WRITE)
                          && (in_addr_reg < cbm_pkg::ADDR_VRAM);
    assign ctrl_wr.address = in_addr_reg;
    assign ctrl_wr.data    = in_data_reg;

    cbm_bank_regs #(
        .ROM_BANK_BITS (ROM_BANK_BITS)
    ) u_bank_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .mapper_kind (mapper_kind_reg),
        .ctrl_wr     (ctrl_wr),
        .rom_bank    (rom_bank),
        .ram_stat    (ram_stat)
    );

    cbm_addr_decode #(
        .ROM_BANK_BITS (ROM_BANK_BITS)
    ) u_addr_decode (
        .operation        (in_op_reg),
        .address          (in_addr_reg),
        .rom_bank         (rom_bank),
        .ram_stat         (ram_stat),
        .target           (dec_target),
        .physical_address (dec_phys),
        .mirror_write     (dec_mirror)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 24'(out_phys_reg);
    assign m_tuser  = {out_mirror_reg, out_target_reg};

`include "cartridge_bank_mapper_assert.svh"

    `CBM_ASSERT_RST(a_empty_stage_ready, aclk, aresetn, !in_valid_reg |-> s_tready)
    `CBM_ASSERT_RST(a_none_zero_addr, aclk, aresetn, out_valid_reg && out_target_reg == cbm_pkg::TGT_NONE |-> out_phys_reg == '0)
    `CBM_ASSERT_RST(a_mirror_main, aclk, aresetn, out_valid_reg && out_mirror_reg |-> out_target_reg == cbm_pkg::TGT_MAIN)

endmodule

[sv/cbm_bank_regs.sv]
module cbm_bank_regs #(
    parameter int ROM_BANK_BITS = cbm_pkg::ROM_BANK_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [1:0]               mapper_kind,
    input  cbm_pkg::ctrl_wr_t        ctrl_wr,
    output logic [ROM_BANK_BITS-1:0] rom_bank,
    output cbm_pkg::ram_stat_t       ram_stat
);

    logic [ROM_BANK_BITS-1:0] rom_bank_reg, rom_bank_next;
    logic [1:0]               ram_bank_reg, ram_bank_next;
    logic                     ram_enabled_reg, ram_enabled_next;
    logic                     rom_mode_reg, rom_mode_next;

    logic                     mbc1, mbc2;
    logic                     rom_set;
    logic [7:0]               rom_ext;
    logic [7:0]               rom_cand;
    logic [ROM_BANK_BITS-1:0] rom_trunc;
    logic [3:0]               nibble;

    assign mbc1    = (mapper_kind == cbm_pkg::MAPPER_MBC1);
    assign mbc2    = (mapper_kind == cbm_pkg::MAPPER_MBC2);
    assign rom_ext = 8'(rom_bank_reg);
    assign nibble  = ctrl_wr.data[3:0];

    always_comb begin
        ram_bank_next    = ram_bank_reg;
        ram_enabled_next = ram_enabled_reg;
        rom_mode_next    = rom_mode_reg;
        rom_set          = 1'b0;
        rom_cand         = rom_ext;
        if (ctrl_wr.valid) begin
            unique case (ctrl_wr.address[14:13])
                cbm_pkg::REG_RAM_EN: begin
                    if ((mbc1 || mbc2) && !(mbc2 && ctrl_wr.address[4])) begin
                        if (nibble == cbm_pkg::RAM_EN_KEY) begin
                            ram_enabled_next = 1'b1;
                        end else if (nibble == 4'd0) begin
                            ram_enabled_next = 1'b0;
                        end
                    end
                end
                cbm_pkg::REG_ROM_LO: begin
                    if (mbc2) begin
                        rom_set  = 1'b1;
                        rom_cand = {4'd0, ctrl_wr.data[3:0]};
                    end else if (mbc1) begin
                        rom_set  = 1'b1;
                        rom_cand = (rom_ext & cbm_pkg::ROM_HI_MASK)
                                 | (ctrl_wr.data & cbm_pkg::ROM_LO_MASK);
                    end
                end
                cbm_pkg::REG_ROM_HI: begin
                    if (mbc1) begin
                        if (rom_mode_reg) begin
                            rom_set  = 1'b1;
                            // bit 7 is cleared; bits 6:5 take write data bits 1:0
                            rom_cand = {1'b0, ctrl_wr.data[1:0], rom_ext[4:0]};
                        end else begin
                            ram_bank_next = ctrl_wr.data[1:0];
                        end
                    end
                end
                cbm_pkg::REG_MODE: begin
                    if (mbc1) begin
                        rom_mode_next = !ctrl_wr.data[0];
                        if (!ctrl_wr.data[0]) begin
                            ram_bank_next = 2'd0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // bank zero maps to bank one after truncation
    assign rom_trunc     = rom_cand[ROM_BANK_BITS-1:0];
    assign rom_bank_next = !rom_set ? rom_bank_reg :
                           (rom_trunc == '0) ? ROM_BANK_BITS'(1) : rom_trunc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_reg    <= ROM_BANK_BITS'(1);
            ram_bank_reg    <= 2'd0;
            ram_enabled_reg <= 1'b0;
            rom_mode_reg    <= 1'b1;
        end else begin
            rom_bank_reg    <= rom_bank_next;
            ram_bank_reg    <= ram_bank_next;
            ram_enabled_reg <= ram_enabled_next;
            rom_mode_reg    <= rom_mode_next;
        end
    end

    assign rom_bank             = rom_bank_reg;
    assign ram_stat.ram_bank    = ram_bank_reg;
    assign ram_stat.ram_enabled = ram_enabled_reg;

`include "cartridge_bank_mapper_assert.svh"

    `CBM_ASSERT_RST(a_rom_bank_nonzero, aclk, aresetn, rom_bank_reg != '0)
    `CBM_ASSERT_RST(a_rom_mode_ram_bank0, aclk, aresetn, rom_mode_reg |-> ram_bank_reg == 2'd0)
    `CBM_ASSERT_RST(a_bank_hold, aclk, aresetn, !ctrl_wr.valid |=> $stable(rom_bank_reg) && $stable(ram_bank_reg))

endmodule

[sv/cbm_addr_decode.sv]
module cbm_addr_decode #(
    parameter int ROM_BANK_BITS = cbm_pkg::ROM_BANK_BITS_DEF
) (
    input  logic                          operation,
    input  logic [15:0]                   address,
    input  logic [ROM_BANK_BITS-1:0]      rom_bank,
    input  cbm_pkg::ram_stat_t            ram_stat,
    output logic [2:0]                    target,
    output logic [cbm_pkg::PHYS_W-1:0]    physical_address,
    output logic                          mirror_write
);

    localparam int ROM_W = ROM_BANK_BITS + 14;

    logic [ROM_W-1:0]               rom_full;
    logic [21:0]                    rom_wide;
    logic [cbm_pkg::PHYS_W-1:0]     rom_phys;
    logic [cbm_pkg::PHYS_W-1:0]     ram_phys;
    logic [cbm_pkg::PHYS_W-1:0]     bus_phys;
    logic                           in_rom, in_ram, in_echo, in_rsvd, is_special;

    assign rom_full = {rom_bank, address[13:0]};
    assign rom_wide = 22'(rom_full);
    assign rom_phys = rom_wide[cbm_pkg::PHYS_W-1:0];
    assign ram_phys = cbm_pkg::PHYS_W'({ram_stat.ram_bank, address[12:0]});
    assign bus_phys = cbm_pkg::PHYS_W'(address);

    assign in_rom     = (address >= cbm_pkg::ADDR_ROM_LO) && (address < cbm_pkg::ADDR_VRAM);
    assign in_ram     = (address >= cbm_pkg::ADDR_RAM_LO) && (address < cbm_pkg::ADDR_WRAM);
    assign in_echo    = (address >= cbm_pkg::ADDR_ECHO_LO) && (address < cbm_pkg::ADDR_ECHO_HI);
    assign in_rsvd    = (address >= cbm_pkg::ADDR_RSVD_LO) && (address < cbm_pkg::ADDR_RSVD_HI);
    assign is_special = (address == cbm_pkg::ADDR_DIV) || (address == cbm_pkg::ADDR_TAC)
                     || (address == cbm_pkg::ADDR_LY) || (address == cbm_pkg::ADDR_DMA);

    always_comb begin
        target           = cbm_pkg::TGT_MAIN;
        physical_address = bus_phys;
        mirror_write     = 1'b0;
        if (operation == cbm_pkg::OP_READ) begin
            priority if (in_rom) begin
                target           = cbm_pkg::TGT_ROM;
                physical_address = rom_phys;
            end else if (in_ram) begin
                target           = cbm_pkg::TGT_RAM;
                physical_address = ram_phys;
            end else begin
            end
        end else begin
            priority if (address < cbm_pkg::ADDR_VRAM) begin
                // control write, handled by the bank registers
                target           = cbm_pkg::TGT_NONE;
                physical_address = '0;
            end else if (in_ram) begin
                if (ram_stat.ram_enabled) begin
                    target           = cbm_pkg::TGT_RAM;
                    physical_address = ram_phys;
                end else begin
                    target           = cbm_pkg::TGT_NONE;
                    physical_address = '0;
                end
            end else if (in_echo) begin
                mirror_write = 1'b1;
            end else if (in_rsvd) begin
                target           = cbm_pkg::TGT_NONE;
                physical_address = '0;
            end else if (is_special) begin
                target = cbm_pkg::TGT_SPECIAL;
            end else begin
            end
        end
    end

endmodule
